// ===== src/sst_pkg.sv =====
package sst_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SIDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_DIV_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_DIV_Y = 2'd2;

	localparam logic RST_LEFT_SIDE = 1'b1;
	localparam logic [7:0] RST_DECAY_DIV = 8'd4;

	localparam logic signed [10:0] TERM_MAX = 11'sd255;
	localparam logic signed [10:0] TERM_MIN = -11'sd255;

	typedef logic signed [8:0] term_t;
	typedef logic signed [10:0] wide_t;

	typedef struct packed {
		logic start;
		logic [7:0] dividend;
		logic [7:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [7:0] quot;
	} div_rsp_t;

	function automatic logic [7:0] mag(input term_t t);
		term_t n;
		n = -t;
		return t[8] ? n[7:0] : t[7:0];
	endfunction

	function automatic term_t sat(input wide_t v);
		if (v > TERM_MAX) begin
			return TERM_MAX[8:0];
		end else if (v < TERM_MIN) begin
			return TERM_MIN[8:0];
		end
		return v[8:0];
	endfunction

	function automatic term_t decay(input term_t t, input logic [7:0] div,
			input logic [7:0] q);
		logic [7:0] m;
		term_t r;
		m = mag(t);
		r = {1'b0, m - q};
		if (div == 8'd0 || q == 8'd0) begin
			return '0;
		end
		return t[8] ? -r : r;
	endfunction

endpackage

// ===== src/sst_if.sv =====
interface sst_cmd_if;
	logic valid;
	logic ready;
	logic action;
	logic signed [9:0] delta_x;
	logic signed [9:0] delta_y;
	logic tick_x;
	logic tick_y;

	modport source(output valid, action, delta_x, delta_y, tick_x, tick_y, input ready);
	modport sink(input valid, action, delta_x, delta_y, tick_x, tick_y, output ready);
endinterface

interface sst_rsp_if;
	logic valid;
	logic ready;
	logic signed [8:0] speed;
	logic [7:0] pwm_duty;
	logic drive_a;
	logic drive_b;

	modport source(output valid, speed, pwm_duty, drive_a, drive_b, input ready);
	modport sink(input valid, speed, pwm_duty, drive_a, drive_b, output ready);
endinterface

interface sst_cfg_if;
	logic valid;
	logic ready;
	logic [sst_pkg::CFG_IDX_W-1:0] index;
	logic [sst_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/sst_div.sv =====
module sst_div (
	input logic clk,
	input logic arst_n,
	input sst_pkg::div_req_t req,
	output sst_pkg::div_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	logic [2:0] cnt_q;
	logic [7:0] rem_q;
	logic [7:0] dq_q;
	logic [7:0] div_q;
	logic [8:0] shifted;
	logic fits;
	logic [7:0] diff;

	assign shifted = {rem_q, dq_q[7]};
	assign diff = shifted[7:0] - div_q;
	assign fits = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff : shifted[7:0];
			dq_q <= {dq_q[6:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = dq_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a run");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q || $past(req.start)) else $error("done held");

endmodule

// ===== src/skid_steer_throttle_decay_core.sv =====
// Keeps a steering and a throttle term (each held within -255..255) and returns the
// saturated sum with PWM duty and bridge pins after each update or decay tick. An update
// passes through the UPD and SUM states to the output register; a tick on one or both
// axes waits in DIVX and/or DIVY for the shared 8-step restoring divider, which computes
// each decay quotient in turn. A tick that selects neither axis returns to idle with no
// result. The command channel takes a new item as soon as the sequencer is idle, while a
// result may still wait in the output register; configuration writes are always taken.
module skid_steer_throttle_decay_core (
	input logic clk,
	input logic arst_n,
	sst_cmd_if.sink cmd,
	sst_rsp_if.source rsp,
	sst_cfg_if.sink cfg
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD = 3'd1;
	localparam logic [2:0] ST_DIVX = 3'd2;
	localparam logic [2:0] ST_DIVY = 3'd3;
	localparam logic [2:0] ST_SUM = 3'd4;

	logic [2:0] state_q;
	logic left_side_q;
	logic [7:0] div_x_q;
	logic [7:0] div_y_q;
	sst_pkg::term_t steer_q;
	sst_pkg::term_t throttle_q;
	logic signed [9:0] delta_x_q;
	logic signed [9:0] delta_y_q;
	logic tick_y_q;
	logic out_valid_q;
	logic signed [8:0] speed_q;
	logic [7:0] duty_q;
	logic drive_a_q;
	logic drive_b_q;

	sst_pkg::div_req_t dreq;
	sst_pkg::div_rsp_t drsp;

	logic cmd_xfer;
	logic out_load;
	sst_pkg::wide_t steer_sum;
	sst_pkg::wide_t thr_sum;
	sst_pkg::wide_t tot_sum;
	sst_pkg::term_t speed_c;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_xfer = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign out_load = (state_q == ST_SUM) && (!out_valid_q || rsp.ready);

	assign thr_sum = {{2{throttle_q[8]}}, throttle_q} + {delta_y_q[9], delta_y_q};
	assign steer_sum = left_side_q
		? {{2{steer_q[8]}}, steer_q} + {delta_x_q[9], delta_x_q}
		: {{2{steer_q[8]}}, steer_q} - {delta_x_q[9], delta_x_q};
	assign tot_sum = {{2{steer_q[8]}}, steer_q} + {{2{throttle_q[8]}}, throttle_q};
	assign speed_c = sst_pkg::sat(tot_sum);

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = sst_pkg::mag(steer_q);
		dreq.divisor = div_x_q;
		if (cmd_xfer && cmd.action && cmd.tick_x) begin
			dreq.start = 1'b1;
		end else if (cmd_xfer && cmd.action && cmd.tick_y) begin
			dreq.start = 1'b1;
			dreq.dividend = sst_pkg::mag(throttle_q);
			dreq.divisor = div_y_q;
		end else if (state_q == ST_DIVX && drsp.done && tick_y_q) begin
			dreq.start = 1'b1;
			dreq.dividend = sst_pkg::mag(throttle_q);
			dreq.divisor = div_y_q;
		end
	end

	sst_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_side_q <= sst_pkg::RST_LEFT_SIDE;
			div_x_q <= sst_pkg::RST_DECAY_DIV;
			div_y_q <= sst_pkg::RST_DECAY_DIV;
		end else if (cfg.valid) begin
			case (cfg.index)
				sst_pkg::CFG_LEFT_SIDE: left_side_q <= cfg.data[0];
				sst_pkg::CFG_DECAY_DIV_X: div_x_q <= cfg.data;
				sst_pkg::CFG_DECAY_DIV_Y: div_y_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			steer_q <= '0;
			throttle_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						if (!cmd.action) begin
							state_q <= ST_UPD;
						end else if (cmd.tick_x) begin
							state_q <= ST_DIVX;
						end else if (cmd.tick_y) begin
							state_q <= ST_DIVY;
						end
					end
				end
				ST_UPD: begin
					steer_q <= sst_pkg::sat(steer_sum);
					throttle_q <= sst_pkg::sat(thr_sum);
					state_q <= ST_SUM;
				end
				ST_DIVX: begin
					if (drsp.done) begin
						steer_q <= sst_pkg::decay(steer_q, div_x_q, drsp.quot);
						state_q <= tick_y_q ? ST_DIVY : ST_SUM;
					end
				end
				ST_DIVY: begin
					if (drsp.done) begin
						throttle_q <= sst_pkg::decay(throttle_q, div_y_q, drsp.quot);
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			delta_x_q <= cmd.delta_x;
			delta_y_q <= cmd.delta_y;
			tick_y_q <= cmd.tick_y;
		end
		if (out_load) begin
			speed_q <= speed_c;
			duty_q <= sst_pkg::mag(speed_c);
			drive_a_q <= speed_c[8];
			drive_b_q <= !speed_c[8] && (speed_c != '0);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.speed = speed_q;
	assign rsp.pwm_duty = duty_q;
	assign rsp.drive_a = drive_a_q;
	assign rsp.drive_b = drive_b_q;

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !drsp.busy && !drsp.done) else $error("divider active while idle");
	a_terms_range: assert property (@(posedge clk) disable iff (!arst_n)
		steer_q != -9'sd256 && throttle_q != -9'sd256) else $error("term out of range");
	a_upd_to_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |=> state_q == ST_SUM) else $error("update not followed by sum");
	a_pins_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(drive_a_q && drive_b_q)) else $error("both bridge pins set");

endmodule

// ===== sim/sst_tb_pkg.sv =====
`timescale 1ns / 100ps
package sst_tb_pkg;

	typedef enum logic {
		ACT_UPDATE = 1'b0,
		ACT_TICK = 1'b1
	} action_e;

	typedef struct packed {
		logic signed [8:0] speed;
		logic [7:0] pwm_duty;
		logic drive_a;
		logic drive_b;
	} drive_t;

endpackage

// ===== sim/sst_drive_checker.sv =====
`timescale 1ns / 100ps
module sst_drive_checker (
	input logic clk,
	input logic arst_n,
	sst_cmd_if cmd,
	sst_rsp_if rsp,
	sst_cfg_if cfg,
	output int errors,
	output int pending
);
	import sst_pkg::*;
	import sst_tb_pkg::*;

	localparam int TERM_LIMIT = 255;

	drive_t expected_drive[$];
	int steer;
	int throttle;
	int fails;
	logic left_side;
	logic [7:0] div_x;
	logic [7:0] div_y;

	function automatic int clamp_term(input int v);
		if (v > TERM_LIMIT) begin
			return TERM_LIMIT;
		end
		if (v < -TERM_LIMIT) begin
			return -TERM_LIMIT;
		end
		return v;
	endfunction

	// quotient truncates toward zero; a zero quotient or divisor clears the term
	function automatic int decayed_term(input int t, input logic [7:0] div);
		int q;
		if (div == 8'd0) begin
			return 0;
		end
		q = t / int'(div);
		return (q == 0) ? 0 : t - q;
	endfunction

	function automatic drive_t drive_for(input int s, input int t);
		drive_t d;
		int sum;
		sum = clamp_term(s + t);
		d.speed = sum[8:0];
		d.pwm_duty = 8'((sum < 0) ? -sum : sum);
		d.drive_a = (sum < 0);
		d.drive_b = (sum > 0);
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		drive_t got;
		drive_t want;
		int dx;
		int dy;
		if (!arst_n) begin
			steer = 0;
			throttle = 0;
			fails = 0;
			left_side = RST_LEFT_SIDE;
			div_x = RST_DECAY_DIV;
			div_y = RST_DECAY_DIV;
			expected_drive.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = {rsp.speed, rsp.pwm_duty, rsp.drive_a, rsp.drive_b};
				if (expected_drive.size() == 0) begin
					if (fails < 10) begin
						$display("%0t: unexpected result speed %0d duty %0d a %b b %b",
							$time, got.speed, got.pwm_duty, got.drive_a, got.drive_b);
					end
					fails++;
				end else begin
					want = expected_drive.pop_front();
					if (got.speed !== want.speed || got.pwm_duty !== want.pwm_duty ||
							got.drive_a !== want.drive_a || got.drive_b !== want.drive_b) begin
						if (fails < 10) begin
							$write("%0t: mismatch (exp/got) speed %0d/%0d duty %0d/%0d",
								$time, want.speed, got.speed, want.pwm_duty, got.pwm_duty);
							$display(" a %b/%b b %b/%b", want.drive_a, got.drive_a,
								want.drive_b, got.drive_b);
						end
						fails++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_LEFT_SIDE: left_side = cfg.data[0];
					CFG_DECAY_DIV_X: div_x = cfg.data;
					CFG_DECAY_DIV_Y: div_y = cfg.data;
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready) begin
				if (cmd.action == ACT_UPDATE) begin
					dx = cmd.delta_x;
					dy = cmd.delta_y;
					throttle = clamp_term(throttle + dy);
					steer = clamp_term(left_side ? steer + dx : steer - dx);
					expected_drive.push_back(drive_for(steer, throttle));
				end else if (cmd.tick_x || cmd.tick_y) begin
					if (cmd.tick_x) begin
						steer = decayed_term(steer, div_x);
					end
					if (cmd.tick_y) begin
						throttle = decayed_term(throttle, div_y);
					end
					expected_drive.push_back(drive_for(steer, throttle));
				end
			end
			errors <= fails;
			pending <= expected_drive.size();
		end
	end

endmodule

// ===== sim/tb_skid_steer_throttle_decay_core.sv =====
`timescale 1ns / 100ps
module tb_skid_steer_throttle_decay_core;
	import sst_pkg::*;
	import sst_tb_pkg::*;

	localparam int LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 92;

	logic clk;
	logic arst_n;
	logic eager;
	int hold_req;
	int errors;
	int pending;

	sst_cmd_if cmd_ch();
	sst_rsp_if rsp_ch();
	sst_cfg_if cfg_ch();

	skid_steer_throttle_decay_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	sst_drive_checker drive_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch),
		.errors(errors),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin : watchdog
		repeat (LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin : receiver
		int wait_left;
		int holds_done;
		wait_left = 0;
		holds_done = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_done) begin
				holds_done = hold_req;
				wait_left = 0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else if (rsp_ch.valid && rsp_ch.ready) begin
				wait_left = eager ? 0 : $urandom_range(0, 3);
				rsp_ch.ready <= (wait_left == 0);
			end else if (wait_left > 0) begin
				wait_left--;
				rsp_ch.ready <= (wait_left == 0);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input action_e act, input logic signed [9:0] dx,
			input logic signed [9:0] dy, input logic tx, input logic ty);
		int gap;
		gap = eager ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.delta_x <= dx;
		cmd_ch.delta_y <= dy;
		cmd_ch.tick_x <= tx;
		cmd_ch.tick_y <= ty;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	// wait for every outstanding result, then let a no-result tick finish
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_div();
		case ($urandom_range(0, 7))
			0: return 8'd1;
			1: return 8'd255;
			2: return 8'd0;
			3: return 8'd2;
			4, 5: return 8'($urandom_range(1, 8));
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic signed [9:0] pick_delta();
		int v;
		if ($urandom_range(0, 3) == 0) begin
			return 10'($urandom);
		end
		v = $urandom_range(0, 80) - 40;
		return 10'(v);
	endfunction

	task automatic random_item();
		logic tx;
		logic ty;
		tx = 1'($urandom);
		ty = 1'($urandom);
		if ($urandom_range(0, 99) < 55) begin
			send_item(ACT_UPDATE, pick_delta(), pick_delta(), tx, ty);
		end else begin
			send_item(ACT_TICK, 10'($urandom), 10'($urandom), tx, ty);
		end
	endtask

	initial begin : stimulus
		cmd_ch.valid = 1'b0;
		cmd_ch.action = ACT_UPDATE;
		cmd_ch.delta_x = '0;
		cmd_ch.delta_y = '0;
		cmd_ch.tick_x = 1'b0;
		cmd_ch.tick_y = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_LEFT_SIDE;
		cfg_ch.data = '0;
		eager = 1'b0;
		hold_req = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: left side, divisors of 4
		send_item(ACT_UPDATE, 10'sd511, 10'sd511, 1'b0, 1'b0);
		send_item(ACT_UPDATE, -10'sd512, -10'sd512, 1'b0, 1'b0);
		send_item(ACT_TICK, 10'sd0, 10'sd0, 1'b1, 1'b1);
		send_item(ACT_TICK, 10'sd0, 10'sd0, 1'b1, 1'b0);
		send_item(ACT_TICK, 10'sd0, 10'sd0, 1'b0, 1'b1);
		send_item(ACT_TICK, -10'sd1, -10'sd1, 1'b0, 1'b0);
		send_item(ACT_UPDATE, 10'sd144, 10'sd144, 1'b1, 1'b1);
		send_item(ACT_UPDATE, 10'sd3, -10'sd3, 1'b0, 1'b0);
		send_item(ACT_TICK, 10'sd0, 10'sd0, 1'b1, 1'b1);
		send_item(ACT_UPDATE, 10'sd100, 10'sd200, 1'b0, 1'b0);
		send_item(ACT_UPDATE, -10'sd300, -10'sd301, 1'b0, 1'b0);

		write_reg(CFG_LEFT_SIDE, 8'hfe);
		write_reg(CFG_DECAY_DIV_X, 8'd1);
		write_reg(CFG_DECAY_DIV_Y, 8'd255);
		send_item(ACT_UPDATE, 10'sd50, 10'sd255, 1'b0, 1'b0);
		send_item(ACT_UPDATE, -10'sd511, 10'sd0, 1'b0, 1'b0);
		send_item(ACT_TICK, 10'sd0, 10'sd0, 1'b1, 1'b1);
		send_item(ACT_UPDATE, 10'sd0, 10'sd255, 1'b0, 1'b0);
		send_item(ACT_TICK, 10'sd0, 10'sd0, 1'b0, 1'b1);

		// zero divisors clear the term; index 3 is not a register
		write_reg(CFG_LEFT_SIDE, 8'h01);
		write_reg(CFG_DECAY_DIV_X, 8'd0);
		write_reg(CFG_DECAY_DIV_Y, 8'd0);
		send_item(ACT_UPDATE, 10'sd77, -10'sd33, 1'b0, 1'b0);
		send_item(ACT_TICK, 10'sd0, 10'sd0, 1'b1, 1'b1);
		write_reg(2'd3, 8'hff);
		send_item(ACT_UPDATE, -10'sd512, 10'sd511, 1'b0, 1'b0);
		send_item(ACT_TICK, 10'sd0, 10'sd0, 1'b1, 1'b0);

		for (int phase = 0; phase < PHASES; phase++) begin
			write_reg(CFG_LEFT_SIDE, 8'($urandom));
			case (phase)
				0: begin
					write_reg(CFG_DECAY_DIV_X, 8'd255);
					write_reg(CFG_DECAY_DIV_Y, 8'd1);
				end
				1: begin
					write_reg(CFG_DECAY_DIV_X, 8'd1);
					write_reg(CFG_DECAY_DIV_Y, 8'd255);
				end
				default: begin
					write_reg(CFG_DECAY_DIV_X, pick_div());
					write_reg(CFG_DECAY_DIV_Y, pick_div());
				end
			endcase
			eager <= (phase % 4 == 3) || (phase == 2);
			if (phase == 2) begin
				hold_req <= hold_req + 1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 5 && n == PHASE_ITEMS / 2) begin
					drain();
				end
				random_item();
			end
		end
		eager <= 1'b0;

		drain();
		if (errors == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
